// File: sv/ecg_pkg.sv
`default_nettype none
package ecg_pkg;

	localparam int PHASE_BITS      = 48;
	localparam int TABLE_ADDR_BITS = 10;
	localparam int SAMPLE_BITS     = 16;

	localparam int TBL_SIZE = 1 << TABLE_ADDR_BITS;
	localparam int TBL_BITS = SAMPLE_BITS - 1;
	localparam int AMP_MAX  = (1 << (SAMPLE_BITS - 1)) - 1;

	localparam int CFG_INDEX_BITS = 2;
	localparam int CFG_DATA_BITS  = 48;
	localparam int COUNT_BITS     = 24;
	localparam int STEP_CHG_BITS  = 32;
	localparam int STEP_BITS      = 48;

	localparam logic [CFG_INDEX_BITS-1:0] REG_CYCLE_LENGTH = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_START_STEP   = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_STEP_CHANGE  = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FADE_STEP    = 2'd3;

	localparam logic [COUNT_BITS-1:0]    CYCLE_LENGTH_RST = 24'd176400;
	localparam logic [STEP_BITS-1:0]     START_STEP_RST   = 48'd2808383050000;
	localparam logic [STEP_CHG_BITS-1:0] STEP_CHANGE_RST  = 32'd31840800;
	localparam logic [STEP_BITS-1:0]     FADE_STEP_RST    = 48'd1595663133;

	localparam longint unsigned HALF_PI_Q30 = 64'd1686629713;

	typedef logic [TBL_BITS-1:0] tbl_word_t;
	typedef tbl_word_t tbl_arr_t [TBL_SIZE];

	typedef struct packed {
		logic [TABLE_ADDR_BITS-1:0] tone_idx;
		logic [TABLE_ADDR_BITS-1:0] fade_idx;
		logic                       tone_neg;
		logic                       fade_neg;
		logic                       first;
	} tap_t;

	typedef struct packed {
		logic load_s1;
		logic load_s2;
		logic load_out;
	} pipe_ctl_t;

	// Truncating long division, one quotient bit per step.
	function automatic longint unsigned udiv64(input longint unsigned num,
			input longint unsigned den);
		longint unsigned quo;
		longint unsigned rem;
		quo = '0;
		rem = '0;
		for (int i = 63; i >= 0; i--) begin
			rem = {rem[62:0], num[i]};
			if (rem >= den) begin
				rem    = rem - den;
				quo[i] = 1'b1;
			end
		end
		return quo;
	endfunction

	// Quarter-wave sine, each entry taken at the middle of its slot and
	// evaluated as a truncating Taylor series in Q30.
	function automatic tbl_arr_t build_sine_tbl();
		tbl_arr_t        tbl;
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned v;
		longint          sum;
		longint unsigned dv;
		for (int k = 0; k < TBL_SIZE; k++) begin
			x    = ((64'(2 * k) + 64'd1) * HALF_PI_Q30) >> (TABLE_ADDR_BITS + 1);
			x2   = (x * x) >> 30;
			term = x;
			sum  = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				dv   = 64'((2 * n) * (2 * n + 1));
				term = udiv64((term * x2) >> 30, dv);
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			v = (longint'(sum) * 64'(AMP_MAX) + (64'd1 << 29)) >> 30;
			if (v > 64'(AMP_MAX)) begin
				v = 64'(AMP_MAX);
			end
			tbl[k] = TBL_BITS'(v);
		end
		return tbl;
	endfunction

	localparam tbl_arr_t SINE_TBL = build_sine_tbl();

endpackage
`default_nettype wire

// File: sv/ecg_ram.sv
`default_nettype none
module ecg_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_a,
	input  wire logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic      [WIDTH-1:0]         rdata_a,
	output logic      [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_a <= mem_q[raddr_a];
			rdata_b <= mem_q[raddr_b];
		end
	end

endmodule
`default_nettype wire

// File: sv/ecg_tbl_fill.sv
`default_nettype none
module ecg_tbl_fill (
	input  wire logic                                  clk,
	input  wire logic                                  arst_n,
	output logic                                       we,
	output logic [ecg_pkg::TABLE_ADDR_BITS-1:0]        waddr,
	output ecg_pkg::tbl_word_t                         wdata,
	output logic                                       done
);
	import ecg_pkg::*;

	logic [TABLE_ADDR_BITS:0] cnt_q;

	assign done  = cnt_q[TABLE_ADDR_BITS];
	assign we    = !done;
	assign waddr = cnt_q[TABLE_ADDR_BITS-1:0];
	assign wdata = SINE_TBL[cnt_q[TABLE_ADDR_BITS-1:0]];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (!done) begin
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule
`default_nettype wire

// File: sv/ecg_sweep.sv
`default_nettype none
module ecg_sweep (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [ecg_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  wire logic [ecg_pkg::CFG_DATA_BITS-1:0]   cfg_data,
	input  wire logic                                step,
	input  wire logic                                restart,
	output ecg_pkg::tap_t                            tap
);
	import ecg_pkg::*;

	logic [COUNT_BITS-1:0]    cycle_length_q;
	logic [STEP_BITS-1:0]     start_step_q;
	logic [STEP_CHG_BITS-1:0] step_change_q;
	logic [STEP_BITS-1:0]     fade_step_q;

	logic [COUNT_BITS-1:0] cnt_q;
	logic [PHASE_BITS-1:0] tone_phase_q;
	logic [PHASE_BITS-1:0] tone_step_q;
	logic [PHASE_BITS-1:0] fade_phase_q;

	logic [COUNT_BITS-1:0] cnt_cur;
	logic [PHASE_BITS-1:0] tone_phase_cur;
	logic [PHASE_BITS-1:0] tone_step_cur;
	logic [PHASE_BITS-1:0] fade_phase_cur;
	logic [PHASE_BITS-1:0] start_step_ext;
	logic [COUNT_BITS-1:0] len;
	logic [COUNT_BITS:0]   cnt_nxt;
	logic                  wrap;
	logic [1:0]            tone_quad;
	logic [1:0]            fade_quad;
	logic [TABLE_ADDR_BITS-1:0] tone_raw;
	logic [TABLE_ADDR_BITS-1:0] fade_raw;

	assign start_step_ext = PHASE_BITS'(start_step_q);

	always_comb begin
		cnt_cur        = restart ? '0 : cnt_q;
		tone_phase_cur = restart ? '0 : tone_phase_q;
		tone_step_cur  = restart ? start_step_ext : tone_step_q;
		fade_phase_cur = restart ? '0 : fade_phase_q;
		len     = (cycle_length_q == '0) ? COUNT_BITS'(1) : cycle_length_q;
		cnt_nxt = {1'b0, cnt_cur} + 1'b1;
		wrap    = cnt_nxt >= {1'b0, len};
	end

	// The cosine of the fade is the sine a quarter turn ahead.
	always_comb begin
		tone_quad = tone_phase_cur[PHASE_BITS-1 -: 2];
		fade_quad = fade_phase_cur[PHASE_BITS-1 -: 2] + 2'd1;
		tone_raw  = tone_phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		fade_raw  = fade_phase_cur[PHASE_BITS-3 -: TABLE_ADDR_BITS];
		tap.tone_idx = tone_quad[0] ? ~tone_raw : tone_raw;
		tap.fade_idx = fade_quad[0] ? ~fade_raw : fade_raw;
		tap.tone_neg = tone_quad[1];
		tap.fade_neg = fade_quad[1];
		tap.first    = (cnt_cur == '0);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cycle_length_q <= CYCLE_LENGTH_RST;
			start_step_q   <= START_STEP_RST;
			step_change_q  <= STEP_CHANGE_RST;
			fade_step_q    <= FADE_STEP_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_CYCLE_LENGTH: cycle_length_q <= cfg_data[COUNT_BITS-1:0];
				REG_START_STEP:   start_step_q   <= cfg_data[STEP_BITS-1:0];
				REG_STEP_CHANGE:  step_change_q  <= cfg_data[STEP_CHG_BITS-1:0];
				REG_FADE_STEP:    fade_step_q    <= cfg_data[STEP_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			tone_phase_q <= '0;
			tone_step_q  <= PHASE_BITS'(START_STEP_RST);
			fade_phase_q <= '0;
		end else if (step) begin
			if (wrap) begin
				cnt_q        <= '0;
				tone_phase_q <= '0;
				tone_step_q  <= start_step_ext;
				fade_phase_q <= '0;
			end else begin
				cnt_q        <= cnt_nxt[COUNT_BITS-1:0];
				tone_phase_q <= tone_phase_cur + tone_step_cur;
				tone_step_q  <= tone_step_cur + PHASE_BITS'(step_change_q);
				fade_phase_q <= fade_phase_cur + PHASE_BITS'(fade_step_q);
			end
		end
	end

endmodule
`default_nettype wire

// File: sv/ecg_mixer.sv
`default_nettype none
module ecg_mixer (
	input  wire logic                                   clk,
	input  ecg_pkg::pipe_ctl_t                          ctl,
	input  ecg_pkg::tap_t                               tap,
	input  ecg_pkg::tbl_word_t                          tone_val,
	input  ecg_pkg::tbl_word_t                          fade_val,
	output logic signed [ecg_pkg::SAMPLE_BITS-1:0]      sample,
	output logic                                        cycle_start
);
	import ecg_pkg::*;

	localparam int PROD_BITS = 2 * SAMPLE_BITS;
	localparam logic [SAMPLE_BITS:0]   AMP_W = (SAMPLE_BITS + 1)'(AMP_MAX);
	localparam logic [SAMPLE_BITS+1:0] DIV_M = (SAMPLE_BITS + 2)'(2 * AMP_MAX);

	logic tone_neg_s1;
	logic fade_neg_s1;
	logic first_s1;

	logic [PROD_BITS-1:0] prod_s2;
	logic                 neg_s2;
	logic                 first_s2;

	logic [SAMPLE_BITS:0]    fv;
	logic [PROD_BITS-1:0]    num;
	logic [SAMPLE_BITS-1:0]  q1;
	logic [SAMPLE_BITS+1:0]  r1;
	logic [SAMPLE_BITS:0]    quot;
	logic [TBL_BITS-1:0]     mag;
	logic signed [SAMPLE_BITS-1:0] smp;

	always_ff @(posedge clk) begin
		if (ctl.load_s1) begin
			tone_neg_s1 <= tap.tone_neg;
			fade_neg_s1 <= tap.fade_neg;
			first_s1    <= tap.first;
		end
	end

	// Fade factor is A minus the cosine, so it runs from 0 to 2A.
	always_comb begin
		fv = fade_neg_s1 ? AMP_W + (SAMPLE_BITS + 1)'(fade_val)
		                 : AMP_W - (SAMPLE_BITS + 1)'(fade_val);
	end

	always_ff @(posedge clk) begin
		if (ctl.load_s2) begin
			prod_s2  <= PROD_BITS'(tone_val) * PROD_BITS'(fv);
			neg_s2   <= tone_neg_s1;
			first_s2 <= first_s1;
		end
	end

	// Division by 2A = 2^SAMPLE_BITS - 2: the first estimate from the upper
	// bits leaves a remainder below twice the divisor, so one correction
	// step is enough.
	always_comb begin
		num  = prod_s2 + PROD_BITS'(AMP_MAX);
		q1   = num[PROD_BITS-1:SAMPLE_BITS];
		r1   = (SAMPLE_BITS + 2)'(num[SAMPLE_BITS-1:0]) + {1'b0, q1, 1'b0};
		quot = {1'b0, q1} + ((r1 >= DIV_M) ? (SAMPLE_BITS + 1)'(1) : '0);
		mag  = (quot > AMP_W) ? TBL_BITS'(AMP_MAX) : quot[TBL_BITS-1:0];
		smp  = neg_s2 ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
	end

	always_ff @(posedge clk) begin
		if (ctl.load_out) begin
			sample      <= smp;
			cycle_start <= first_s2;
		end
	end

endmodule
`default_nettype wire

// File: sv/enveloped_chirp_generator_top.sv
// An accepted word passes the first-stage, second-stage and output registers to out_valid.
// Throughput: one word per cycle unless out_ready stalls; accumulators update in the acceptance cycle.
// The two sine lookups share one table RAM with two registered read ports.
// After reset the table is loaded from constants while in_ready is low;
// configuration writes are taken at all times.
`default_nettype none
module enveloped_chirp_generator_top (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_valid,
	output logic                                        cfg_ready,
	input  wire logic [ecg_pkg::CFG_INDEX_BITS-1:0]     cfg_index,
	input  wire logic [ecg_pkg::CFG_DATA_BITS-1:0]      cfg_data,
	input  wire logic                                   in_valid,
	output logic                                        in_ready,
	input  wire logic                                   restart,
	output logic                                        out_valid,
	input  wire logic                                   out_ready,
	output logic signed [ecg_pkg::SAMPLE_BITS-1:0]      sample,
	output logic                                        cycle_start
);
	import ecg_pkg::*;

	tap_t      tap;
	pipe_ctl_t ctl;

	logic                       fill_we;
	logic [TABLE_ADDR_BITS-1:0] fill_addr;
	tbl_word_t                  fill_data;
	logic                       fill_done;
	tbl_word_t                  tone_val;
	tbl_word_t                  fade_val;

	logic s1_v_q;
	logic s2_v_q;
	logic out_v_q;
	logic accept;
	logic out_en;
	logic s2_en;
	logic s1_en;

	assign cfg_ready = 1'b1;
	assign out_valid = out_v_q;

	assign out_en   = !out_v_q || out_ready;
	assign s2_en    = !s2_v_q || out_en;
	assign s1_en    = !s1_v_q || s2_en;
	assign in_ready = fill_done && s1_en;
	assign accept   = in_valid && in_ready;

	assign ctl.load_s1  = accept;
	assign ctl.load_s2  = s1_v_q && s2_en;
	assign ctl.load_out = s2_v_q && out_en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v_q  <= 1'b0;
			s2_v_q  <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (s1_en) begin
				s1_v_q <= accept;
			end
			if (s2_en) begin
				s2_v_q <= s1_v_q;
			end
			if (out_en) begin
				out_v_q <= s2_v_q;
			end
		end
	end

	ecg_tbl_fill u_fill (
		.clk    (clk),
		.arst_n (arst_n),
		.we     (fill_we),
		.waddr  (fill_addr),
		.wdata  (fill_data),
		.done   (fill_done)
	);

	ecg_ram #(
		.WIDTH (TBL_BITS),
		.DEPTH (TBL_SIZE)
	) u_sine_ram (
		.clk     (clk),
		.we      (fill_we),
		.waddr   (fill_addr),
		.wdata   (fill_data),
		.re      (accept),
		.raddr_a (tap.tone_idx),
		.raddr_b (tap.fade_idx),
		.rdata_a (tone_val),
		.rdata_b (fade_val)
	);

	ecg_sweep u_sweep (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.step      (accept),
		.restart   (restart),
		.tap       (tap)
	);

	ecg_mixer u_mixer (
		.clk         (clk),
		.ctl         (ctl),
		.tap         (tap),
		.tone_val    (tone_val),
		.fade_val    (fade_val),
		.sample      (sample),
		.cycle_start (cycle_start)
	);

	a_no_accept_while_filling: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> fill_done)
		else $error("input taken before the sine table was loaded");

	a_pipe_empty_while_filling: assert property (@(posedge clk) disable iff (!arst_n)
		!fill_done |-> !(s1_v_q || s2_v_q || out_v_q))
		else $error("pipeline holds a word during the table load");

	a_accept_fills_s1: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> s1_v_q)
		else $error("accepted word did not reach the first stage");

	a_s2_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_s2 |=> s2_v_q)
		else $error("word lost between first and second stage");

	a_out_advance: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.load_out |=> out_v_q)
		else $error("word lost on the way to the output register");

endmodule
`default_nettype wire

// File: dv/enveloped_chirp_generator_checker.sv
`timescale 1ns / 1ps
module enveloped_chirp_generator_checker (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	input  logic                              cfg_ready,
	input  logic [ecg_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [ecg_pkg::CFG_DATA_BITS-1:0]  cfg_data,
	input  logic                              in_valid,
	input  logic                              in_ready,
	input  logic                              restart,
	input  logic                              out_valid,
	input  logic                              out_ready,
	input  logic signed [ecg_pkg::SAMPLE_BITS-1:0] sample,
	input  logic                              cycle_start,
	output int                                errors,
	output int                                pending,
	output int                                compared
);
	import ecg_pkg::*;

	localparam int LUT_BITS = 10;
	localparam int LUT_SIZE = 1 << LUT_BITS;
	localparam int ACC_BITS = 48;
	localparam longint PEAK = 32767;
	localparam longint unsigned HALF_PI_FIX = 64'd1686629713;
	localparam int PRINT_CAP = 40;

	typedef struct packed {
		logic signed [15:0] level;
		logic               first;
	} chirp_t;

	int unsigned quarter_lut [LUT_SIZE];
	chirp_t      chirp_queue [$];

	logic [23:0]         len_reg;
	logic [ACC_BITS-1:0] start_reg;
	logic [31:0]         chg_reg;
	logic [ACC_BITS-1:0] fade_reg;

	logic [23:0]         tick_count;
	logic [ACC_BITS-1:0] tone_acc;
	logic [ACC_BITS-1:0] tone_inc;
	logic [ACC_BITS-1:0] fade_acc;

	task automatic fill_quarter_wave();
		longint unsigned x;
		longint unsigned x2;
		longint unsigned term;
		longint unsigned dv;
		longint unsigned su;
		longint unsigned v;
		longint          sum;
		for (int k = 0; k < LUT_SIZE; k++) begin
			x = 64'(2 * k + 1);
			x = (x * HALF_PI_FIX) >> (LUT_BITS + 1);
			x2 = (x * x) >> 30;
			term = x;
			sum = longint'(x);
			for (int n = 1; n <= 8; n++) begin
				dv = 64'(2 * n * (2 * n + 1));
				term = ((term * x2) >> 30) / dv;
				if (n % 2 == 1) begin
					sum = sum - longint'(term);
				end else begin
					sum = sum + longint'(term);
				end
			end
			if (sum < 0) begin
				sum = 0;
			end
			su = unsigned'(sum);
			v = (su * PEAK + (64'd1 << 29)) >> 30;
			if (v > PEAK) begin
				v = PEAK;
			end
			quarter_lut[k] = 32'(v);
		end
	endtask

	function automatic longint quarter_sine(input logic [ACC_BITS-1:0] ph);
		logic [1:0]          quad;
		logic [LUT_BITS-1:0] idx;
		longint              v;
		quad = ph[ACC_BITS-1 -: 2];
		idx = ph[ACC_BITS-3 -: LUT_BITS];
		if (quad[0]) begin
			idx = LUT_BITS'(LUT_SIZE - 1 - idx);
		end
		v = quarter_lut[idx];
		return quad[1] ? -v : v;
	endfunction

	task automatic rewind_sweep();
		tick_count = '0;
		tone_acc = '0;
		tone_inc = start_reg;
		fade_acc = '0;
	endtask

	task automatic predict_tick(input logic rbit, output chirp_t res);
		longint      s;
		longint      c;
		longint      fv;
		longint      mag;
		longint      lvl;
		logic [24:0] span;
		logic [24:0] nxt;
		if (rbit) begin
			rewind_sweep();
		end
		s = quarter_sine(tone_acc);
		c = quarter_sine(fade_acc + (48'd1 << (ACC_BITS - 2)));
		fv = PEAK - c;
		mag = (s < 0) ? -s : s;
		mag = (mag * fv + PEAK) / (2 * PEAK);
		if (mag > PEAK) begin
			mag = PEAK;
		end
		lvl = (s < 0) ? -mag : mag;
		res.level = lvl[15:0];
		res.first = (tick_count == 0);
		span = (len_reg == 0) ? 25'd1 : {1'b0, len_reg};
		nxt = {1'b0, tick_count} + 25'd1;
		if (nxt >= span) begin
			rewind_sweep();
		end else begin
			tick_count = nxt[23:0];
			tone_acc = tone_acc + tone_inc;
			tone_inc = tone_inc + {16'd0, chg_reg};
			fade_acc = fade_acc + fade_reg;
		end
	endtask

	task automatic report(input string msg);
		if (errors < PRINT_CAP) begin
			$display("ERROR at %0t: %s", $realtime, msg);
		end
		errors++;
	endtask

	initial begin
		errors = 0;
		compared = 0;
		pending = 0;
		fill_quarter_wave();
	end

	always @(posedge clk or negedge arst_n) begin
		chirp_t want;
		chirp_t fresh;
		if (!arst_n) begin
			len_reg = CYCLE_LENGTH_RST;
			start_reg = START_STEP_RST;
			chg_reg = STEP_CHANGE_RST;
			fade_reg = FADE_STEP_RST;
			rewind_sweep();
			chirp_queue.delete();
			pending = 0;
		end else begin
			if (out_valid && out_ready) begin
				if (chirp_queue.size() == 0) begin
					report($sformatf("output word with nothing expected: sample %0d start %0b",
						sample, cycle_start));
				end else begin
					want = chirp_queue.pop_front();
					compared++;
					if (sample !== want.level) begin
						report($sformatf("sample %0d: got %0d, expected %0d",
							compared, sample, want.level));
					end
					if (cycle_start !== want.first) begin
						report($sformatf("cycle_start of sample %0d: got %b, expected %b",
							compared, cycle_start, want.first));
					end
				end
			end
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					REG_CYCLE_LENGTH: len_reg = cfg_data[23:0];
					REG_START_STEP:   start_reg = cfg_data[47:0];
					REG_STEP_CHANGE:  chg_reg = cfg_data[31:0];
					REG_FADE_STEP:    fade_reg = cfg_data[47:0];
					default: ;
				endcase
			end
			if (in_valid && in_ready) begin
				predict_tick(restart, fresh);
				chirp_queue.push_back(fresh);
			end
			pending = chirp_queue.size();
		end
	end
endmodule

// File: dv/enveloped_chirp_generator_top_tb.sv
`timescale 1ns / 1ps
module enveloped_chirp_generator_top_tb;
	import ecg_pkg::*;

	localparam int LIMIT = 600000;
	localparam int TICK_TARGET = 921;
	localparam int SETTLE = 8;

	logic clk = 1'b0;
	logic arst_n;
	logic cfg_valid;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index;
	logic [CFG_DATA_BITS-1:0]  cfg_data;
	logic in_valid;
	logic in_ready;
	logic restart;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [SAMPLE_BITS-1:0] sample;
	logic cycle_start;

	int errors;
	int pending;
	int compared;

	int cycles = 0;
	int ticks_sent = 0;
	int restarts_sent = 0;
	int settings_used = 0;
	bit tx_steady = 1'b0;
	bit rx_steady = 1'b0;
	int rx_hold = 0;
	int rx_roll;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	enveloped_chirp_generator_top u_top (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.cycle_start(cycle_start)
	);

	enveloped_chirp_generator_checker u_checker (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.restart    (restart),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.sample     (sample),
		.cycle_start(cycle_start),
		.errors     (errors),
		.pending    (pending),
		.compared   (compared)
	);

	always @(posedge clk) begin
		cycles++;
		if (cycles > LIMIT) begin
			$display("Timed out after %0d cycles with %0d samples outstanding.", cycles, pending);
			$display("FAILURE");
			$finish;
		end
	end

	always @(negedge clk) begin
		if (rx_steady) begin
			out_ready <= 1'b1;
		end else if (rx_hold > 0) begin
			out_ready <= 1'b0;
			rx_hold--;
		end else begin
			rx_roll = $urandom_range(99);
			if (rx_roll < 70) begin
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b0;
				rx_hold = (rx_roll < 95) ? $urandom_range(2) : $urandom_range(39, 9);
			end
		end
	end

	function automatic logic [47:0] rand48();
		logic [63:0] w;
		w = {$urandom(), $urandom()};
		return w[47:0];
	endfunction

	function automatic int pick_gap();
		int roll;
		roll = $urandom_range(99);
		if (tx_steady || roll < 70) begin
			return 0;
		end else if (roll < 95) begin
			return $urandom_range(3, 1);
		end
		return $urandom_range(40, 10);
	endfunction

	function automatic logic [23:0] pick_length();
		int roll;
		roll = $urandom_range(99);
		if (roll < 35) begin
			return 24'($urandom_range(16, 1));
		end else if (roll < 60) begin
			return 24'($urandom_range(400, 17));
		end else if (roll < 67) begin
			return 24'd0;
		end else if (roll < 74) begin
			return CYCLE_LENGTH_RST;
		end else if (roll < 80) begin
			return 24'hFFFFFF;
		end else if (roll < 85) begin
			return 24'd1;
		end
		return 24'($urandom());
	endfunction

	function automatic logic [47:0] pick_start();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			return '0;
		end else if (roll < 25) begin
			return '1;
		end else if (roll < 40) begin
			return START_STEP_RST;
		end else if (roll < 55) begin
			return {16'd0, $urandom()};
		end
		return rand48();
	endfunction

	function automatic logic [31:0] pick_change();
		int roll;
		roll = $urandom_range(99);
		if (roll < 15) begin
			return '0;
		end else if (roll < 25) begin
			return '1;
		end else if (roll < 40) begin
			return STEP_CHANGE_RST;
		end
		return $urandom();
	endfunction

	function automatic logic [47:0] pick_fade(input logic [23:0] len);
		int roll;
		logic [47:0] span;
		roll = $urandom_range(99);
		span = (len == 0) ? 48'd1 : {24'd0, len};
		if (roll < 10) begin
			return '0;
		end else if (roll < 20) begin
			return '1;
		end else if (roll < 35) begin
			return FADE_STEP_RST;
		end else if (roll < 65) begin
			return 48'hFFFFFFFFFFFF / span;
		end
		return rand48();
	endfunction

	task automatic send_tick(input logic rbit);
		int gap;
		gap = pick_gap();
		@(negedge clk);
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		restart <= rbit;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		ticks_sent++;
		if (rbit) begin
			restarts_sent++;
		end
	endtask

	task automatic stop_ticks();
		@(negedge clk);
		in_valid <= 1'b0;
	endtask

	task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
			input logic [CFG_DATA_BITS-1:0] data);
		@(negedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= data;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
	endtask

	task automatic end_writes();
		@(negedge clk);
		cfg_valid <= 1'b0;
		settings_used++;
	endtask

	task automatic drain();
		while (pending != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	initial begin
		logic [23:0] len;
		logic [47:0] data;
		int phase_ticks;
		int restart_pct;
		int roll;
		bit first_phase;
		bit do_len;
		bit do_start;
		bit do_chg;
		bit do_fade;

		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		in_valid = 1'b0;
		restart = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register values from reset, with a restart in the middle.
		send_tick(1'b0);
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		stop_ticks();
		drain();

		// A zero cycle length behaves as one: every sample opens a cycle.
		write_reg(REG_CYCLE_LENGTH, {24'hFFFFFF, 24'd0});
		write_reg(REG_START_STEP, '1);
		write_reg(REG_STEP_CHANGE, {16'hFFFF, 32'hFFFFFFFF});
		write_reg(REG_FADE_STEP, '1);
		end_writes();
		send_tick(1'b0);
		send_tick(1'b1);
		send_tick(1'b0);
		stop_ticks();
		drain();

		// Quarter-cycle tone steps against a half-cycle fade reach full scale.
		write_reg(REG_CYCLE_LENGTH, {24'd0, 24'hFFFFFF});
		write_reg(REG_START_STEP, 48'd1 << 46);
		write_reg(REG_STEP_CHANGE, '0);
		write_reg(REG_FADE_STEP, 48'd1 << 47);
		end_writes();
		send_tick(1'b1);
		repeat (7) send_tick(1'b0);
		stop_ticks();
		drain();

		// The counter now sits past the new, shorter cycle and must wrap at once.
		write_reg(REG_CYCLE_LENGTH, 48'd5);
		write_reg(REG_START_STEP, '0);
		write_reg(REG_STEP_CHANGE, 48'hFFFFFFFF);
		write_reg(REG_FADE_STEP, '0);
		end_writes();
		repeat (6) send_tick(1'b0);
		stop_ticks();
		drain();

		first_phase = 1'b1;
		while (ticks_sent < TICK_TARGET) begin
			len = pick_length();
			do_len = first_phase || ($urandom_range(9) < 6);
			do_start = first_phase || ($urandom_range(9) < 6);
			do_chg = first_phase || ($urandom_range(9) < 6);
			do_fade = first_phase || ($urandom_range(9) < 6);
			if (!(do_len || do_start || do_chg || do_fade)) begin
				do_len = 1'b1;
			end
			first_phase = 1'b0;
			if (do_len) begin
				data = rand48();
				data[23:0] = len;
				write_reg(REG_CYCLE_LENGTH, data);
			end
			if (do_start) begin
				write_reg(REG_START_STEP, pick_start());
			end
			if (do_chg) begin
				data = rand48();
				data[31:0] = pick_change();
				write_reg(REG_STEP_CHANGE, data);
			end
			if (do_fade) begin
				write_reg(REG_FADE_STEP, pick_fade(len));
			end
			end_writes();

			tx_steady = ($urandom_range(4) == 0);
			rx_steady = ($urandom_range(4) == 0);
			roll = $urandom_range(99);
			if (roll < 50) begin
				restart_pct = 3;
			end else if (roll < 70) begin
				restart_pct = 0;
			end else if (roll < 90) begin
				restart_pct = 25;
			end else begin
				restart_pct = 100;
			end
			phase_ticks = $urandom_range(120, 20);
			repeat (phase_ticks) send_tick($urandom_range(99) < restart_pct);
			stop_ticks();
			drain();
			rx_steady = 1'b0;
		end

		drain();
		$display("Sent %0d sample ticks (%0d with restart) over %0d register settings.",
			ticks_sent, restarts_sent, settings_used);
		$display("Compared %0d output samples in %0d cycles.", compared, cycles);
		if (errors == 0) begin
			$display("SUCCESS");
		end else begin
			$display("FAILURE");
		end
		$finish;
	end
endmodule

// File: filelist.f
sv/ecg_pkg.sv
sv/ecg_ram.sv
sv/ecg_tbl_fill.sv
sv/ecg_sweep.sv
sv/ecg_mixer.sv
sv/enveloped_chirp_generator_top.sv
dv/enveloped_chirp_generator_checker.sv
dv/enveloped_chirp_generator_top_tb.sv
